/* src/sjis_gfe_pkg.sv */
package sjis_gfe_pkg;

    // result kinds, also used as the item class inside the queue
    typedef enum logic {
        KIND_GLYPH = 1'b0,
        KIND_TEXEL = 1'b1
    } kind_t;

    // configuration register indexes
    localparam logic [1:0] REG_PALETTE_0 = 2'd0;
    localparam logic [1:0] REG_PALETTE_1 = 2'd1;
    localparam logic [1:0] REG_PALETTE_2 = 2'd2;
    localparam logic [1:0] REG_PALETTE_3 = 2'd3;

    localparam logic [15:0] PALETTE_0_RESET = 16'd0;
    localparam logic [15:0] PALETTE_1_RESET = 16'd43338;
    localparam logic [15:0] PALETTE_2_RESET = 16'd48623;
    localparam logic [15:0] PALETTE_3_RESET = 16'd50737;

    // glyph geometry: 6 bytes of 4 pixels per row, 32 rows, 192 bytes per glyph
    localparam logic [2:0]  LAST_COL_BYTE   = 3'd5;
    localparam logic [4:0]  LAST_ROW        = 5'd31;
    localparam logic [3:0]  LAST_PIXEL_BEAT = 4'd3;
    localparam logic [3:0]  LAST_PAD_BEAT   = 4'd11;

    // glyph of the fallback code 0x81a6
    localparam logic [11:0] FALLBACK_INDEX = 12'd101;

    // one classified item waiting for the back end
    typedef struct packed {
        kind_t       kind;
        logic [11:0] glyph_index;
        logic [7:0]  font_byte;
        logic [4:0]  row;
        logic [2:0]  col_byte;
    } work_t;

    function automatic logic [11:0] section_base(input logic [5:0] sect);
        logic [11:0] base;
        case (sect)
            6'd0:  base = 12'h000;
            6'd1:  base = 12'h05E;
            6'd2:  base = 12'h06C;
            6'd3:  base = 12'h0AA;
            6'd4:  base = 12'h0FD;
            6'd5:  base = 12'h153;
            6'd6:  base = 12'h183;
            6'd7:  base = 12'h1C5;
            6'd8:  base = 12'h223;
            6'd9:  base = 12'h281;
            6'd10: base = 12'h2DF;
            6'd11: base = 12'h33D;
            6'd12: base = 12'h39B;
            6'd13: base = 12'h3F9;
            6'd14: base = 12'h457;
            6'd15: base = 12'h4B5;
            6'd16: base = 12'h513;
            6'd17: base = 12'h571;
            6'd18: base = 12'h5CF;
            6'd19: base = 12'h62D;
            6'd20: base = 12'h68B;
            6'd21: base = 12'h6E9;
            6'd22: base = 12'h747;
            6'd23: base = 12'h7A5;
            6'd24: base = 12'h803;
            6'd25: base = 12'h861;
            6'd26: base = 12'h8BF;
            6'd27: base = 12'h91D;
            6'd28: base = 12'h97B;
            6'd29: base = 12'h9D9;
            6'd30: base = 12'hA37;
            6'd31: base = 12'hA95;
            6'd32: base = 12'hAF3;
            6'd33: base = 12'hB51;
            6'd34: base = 12'hBAF;
            6'd35: base = 12'hC0D;
            6'd36: base = 12'hC6B;
            6'd37: base = 12'hCC9;
            6'd38: base = 12'hD27;
            default: base = 12'h000;
        endcase
        return base;
    endfunction

    // shift-jis code to glyph number, fallback glyph for bad codes
    function automatic logic [11:0] glyph_of_code(input logic [15:0] code);
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  row;
        logic [7:0]  sect;
        logic        ok;
        logic [11:0] idx;
        ok = 1'b1;
        hi = code[15:8] + 8'h7f;
        lo = code[7:0] + 8'hc0;
        if (hi >= 8'h6f || (hi >= 8'h1f && hi < 8'h5f))
            ok = 1'b0;
        if (hi >= 8'h1f)
            hi = hi - 8'h40;
        row = {hi[6:0], 1'b0} + 8'h21;
        if (lo >= 8'hbd || lo == 8'h3f)
            ok = 1'b0;
        if (lo < 8'h3f)
            lo = lo + 8'h01;
        if (lo >= 8'h5f)
        begin
            lo  = lo - 8'h3e;
            row = row + 8'h01;
        end
        else
        begin
            lo = lo + 8'h20;
        end
        if (row == 8'h23)
        begin
            // unassigned cells wrap in the 8-bit path
            if (lo >= 8'h61)
                lo = lo - 8'h06;
            if (lo >= 8'h41)
                lo = lo - 8'h07;
            lo = lo - 8'h0f;
        end
        else if (row == 8'h26)
        begin
            if (lo >= 8'h41)
                lo = lo - 8'h08;
        end
        else if (row == 8'h27)
        begin
            if (lo >= 8'h51)
                lo = lo - 8'h0f;
        end
        else if (row >= 8'h28)
        begin
            if (row < 8'h30 || row >= 8'h50)
                ok = 1'b0;
            row = row - 8'h08;
        end
        sect = row - 8'h21;
        if (sect >= 8'd40)
            ok = 1'b0;
        lo  = lo - 8'h21;
        idx = section_base(sect[5:0]) + {4'b0, lo};
        return ok ? idx : FALLBACK_INDEX;
    endfunction

endpackage

/* src/sjis_gfe_front.sv */
module sjis_gfe_front
    import sjis_gfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [15:0] sjis_code,
    input  logic [7:0]  font_byte,
    input  logic        queue_full,
    output logic        push,
    output work_t       push_data
);

    // byte counter kept as row and byte-in-row
    logic [4:0] row_reg;
    logic [4:0] row_next;
    logic [2:0] col_reg;
    logic [2:0] col_next;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_data.kind        = mode ? KIND_TEXEL : KIND_GLYPH;
        push_data.glyph_index = mode ? 12'd0 : glyph_of_code(sjis_code);
        push_data.font_byte   = font_byte;
        push_data.row         = row_reg;
        push_data.col_byte    = col_reg;
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (push)
        begin
            if (!mode)
            begin
                row_next = 5'd0;
                col_next = 3'd0;
            end
            else if (col_reg == LAST_COL_BYTE)
            begin
                col_next = 3'd0;
                // wraps at 192 bytes
                row_next = (row_reg == LAST_ROW) ? 5'd0 : row_reg + 5'd1;
            end
            else
            begin
                col_next = col_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 5'd0;
            col_reg <= 3'd0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

/* src/sjis_gfe_queue.sv */
module sjis_gfe_queue
    import sjis_gfe_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output work_t head,
    output logic  empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);

    work_t           slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full  = (count_reg == FullCount);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* src/sjis_gfe_back.sv */
module sjis_gfe_back
    import sjis_gfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  work_t       head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [11:0] glyph_index,
    output logic [19:0] font_offset,
    output logic [15:0] texel_color,
    output logic [9:0]  texel_position,
    output logic        last
);

    logic [15:0] palette_reg [4];
    logic [3:0]  beat_reg;
    logic [3:0]  beat_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        kind_reg;
    logic [11:0] glyph_reg;
    logic [19:0] offset_reg;
    logic [15:0] color_reg;
    logic [9:0]  pos_reg;
    logic        last_reg;

    logic        is_texel;
    logic        pad;
    logic        last_beat;
    logic        take;
    logic [1:0]  pixel;
    logic [4:0]  column;
    logic [15:0] color;
    logic [19:0] offset;

    assign is_texel  = (head.kind == KIND_TEXEL);
    assign pad       = (head.col_byte == LAST_COL_BYTE);
    assign last_beat = !is_texel
                       || (pad ? (beat_reg == LAST_PAD_BEAT) : (beat_reg == LAST_PIXEL_BEAT));
    assign take      = (!out_valid_reg || out_ready) && !empty;
    assign pop       = take && last_beat;

    // pixels msb first
    always_comb
    begin
        case (beat_reg[1:0])
            2'd0:    pixel = head.font_byte[7:6];
            2'd1:    pixel = head.font_byte[5:4];
            2'd2:    pixel = head.font_byte[3:2];
            default: pixel = head.font_byte[1:0];
        endcase
    end

    // padding beats land on columns 24..31 since the pad byte is byte 5
    assign column = {head.col_byte, 2'b00} + {1'b0, beat_reg};
    assign color  = (beat_reg <= LAST_PIXEL_BEAT) ? palette_reg[pixel] : 16'd0;
    // index * 192 as two shifted copies
    assign offset = {1'b0, head.glyph_index, 7'b0} + {2'b0, head.glyph_index, 6'b0};

    always_comb
    begin
        beat_next      = beat_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            beat_next      = last_beat ? 4'd0 : beat_reg + 4'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
            palette_reg[REG_PALETTE_0] <= PALETTE_0_RESET;
            palette_reg[REG_PALETTE_1] <= PALETTE_1_RESET;
            palette_reg[REG_PALETTE_2] <= PALETTE_2_RESET;
            palette_reg[REG_PALETTE_3] <= PALETTE_3_RESET;
        end
        else
        begin
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
                palette_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg   <= head.kind;
            glyph_reg  <= is_texel ? 12'd0 : head.glyph_index;
            offset_reg <= is_texel ? 20'd0 : offset;
            color_reg  <= is_texel ? color : 16'd0;
            pos_reg    <= is_texel ? {head.row, column} : 10'd0;
            last_reg   <= last_beat;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign glyph_index    = glyph_reg;
    assign font_offset    = offset_reg;
    assign texel_color    = color_reg;
    assign texel_position = pos_reg;
    assign last           = last_reg;

endmodule

/* src/sjis_glyph_fetch_expand_unit.sv */
// shift-jis character generator. a code item (mode 0) turns a two-byte
// shift-jis code into a glyph number and its byte offset (glyph * 192) in a
// 2-bit-per-pixel font, and restarts the glyph byte count; bad codes give the
// glyph of code 0x81a6. a font-byte item (mode 1) is the next packed byte of
// the glyph: its four pixels, msb first, leave as argb1555 texels from the four
// palette registers, each with its position row*32+column in a 32x32 tile;
// after the sixth byte of a row, eight zero texels pad columns 24..31. the
// last result of every item carries last. the front end classifies and maps
// codes in the cycle an item is accepted and queues it; the back end sends
// one result per cycle from its output register while out_ready and a queued
// item allow it. a code item gives one result, a font byte four texels, or
// twelve on the last byte of a row. the queue of QUEUE_DEPTH items lets input
// run ahead of a stalled output. palette registers are written by cfg_write
// with cfg_index 0..3; the user must write them only while no item is in
// flight, which is up to the user: the block has no check for it
module sjis_glyph_fetch_expand_unit
    import sjis_gfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [15:0] sjis_code,
    input  logic [7:0]  font_byte,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [11:0] glyph_index,
    output logic [19:0] font_offset,
    output logic [15:0] texel_color,
    output logic [9:0]  texel_position,
    output logic        last
);

    // front to queue
    logic  push;
    work_t push_data;
    logic  queue_full;
    // queue to back
    logic  pop;
    work_t head;
    logic  queue_empty;

    // classify items, map codes, track the glyph byte position
    sjis_gfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .sjis_code  (sjis_code),
        .font_byte  (font_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // decouples intake from result delivery
    sjis_gfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    // expands each queued item into its results, one per cycle while out_ready allows
    sjis_gfe_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .head           (head),
        .empty          (queue_empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .glyph_index    (glyph_index),
        .font_offset    (font_offset),
        .texel_color    (texel_color),
        .texel_position (texel_position),
        .last           (last)
    );

endmodule
